>>> rtl/surs_pkg.sv
// ----------------------------------------------------------------------------
// surs_pkg
// Types and constants shared by the sum-up rounding selector and its channels.
// ----------------------------------------------------------------------------
package surs_pkg;

    localparam int MAX_CONTROLS = 8;
    localparam int IDX_W        = $clog2(MAX_CONTROLS);
    localparam int FRAC_W       = 17;
    localparam int DEV_W        = 24;
    localparam int CNT_W        = 4;
    localparam int CFG_W        = 17;
    localparam int CFG_IDX_W    = 2;

    typedef logic        [FRAC_W-1:0]    t_frac;
    typedef logic signed [DEV_W-1:0]     t_dev;
    typedef logic        [IDX_W-1:0]     t_idx;
    typedef logic        [CNT_W-1:0]     t_cnt;
    typedef logic        [CFG_W-1:0]     t_cfg_data;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes on the config port
    localparam t_cfg_idx CFG_CONTROLS_IN_USE = 2'd0;
    localparam t_cfg_idx CFG_VANISHING_MODE  = 2'd1;
    localparam t_cfg_idx CFG_ZERO_TOLERANCE  = 2'd2;

    localparam t_cnt  CTRL_RESET = t_cnt'(MAX_CONTROLS);
    localparam t_cnt  CTRL_MAX   = t_cnt'(MAX_CONTROLS);
    localparam t_dev  DEV_MAX    = {1'b0, {(DEV_W-1){1'b1}}};
    localparam t_dev  DEV_MIN    = {1'b1, {(DEV_W-1){1'b0}}};
    localparam t_frac ONE_Q16    = 17'h10000;

endpackage

>>> rtl/surs_in_if.sv
// ----------------------------------------------------------------------------
// surs_in_if
// Request channel carrying one Q1.16 fraction per component.
// ----------------------------------------------------------------------------
interface surs_in_if;
    import surs_pkg::*;

    logic  valid;
    logic  ready;
    t_frac fraction;

    modport source (output valid, output fraction, input ready);
    modport sink   (input valid, input fraction, output ready);
endinterface

>>> rtl/surs_out_if.sv
// ----------------------------------------------------------------------------
// surs_out_if
// Result channel carrying the chosen component of a step.
// ----------------------------------------------------------------------------
interface surs_out_if;
    import surs_pkg::*;

    logic valid;
    logic ready;
    t_idx chosen_index;
    logic none_eligible;

    modport source (output valid, output chosen_index, output none_eligible, input ready);
    modport sink   (input valid, input chosen_index, input none_eligible, output ready);
endinterface

>>> rtl/sum_up_rounding_selector_unit.sv
// ----------------------------------------------------------------------------
// sum_up_rounding_selector_unit
// Sum-up rounding of relaxed fractional controls into one chosen component
// per step (SOS1). Deviations are signed Q7.16 and saturate.
// ----------------------------------------------------------------------------
// Path: the request that closes a step passes the input register, then the
//   update/select stage, before its result is loaded into the output register.
// Throughput: 1 request per cycle while the output is not held back, limited by
//   the single add/compare/update pass on the deviation register file.
// Reset: synchronous, active low; clears deviations, step position, running
//   maximum, pipeline valids and config registers (8, 0, 0). No clearing pass.
// ----------------------------------------------------------------------------
module sum_up_rounding_selector_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port
    input  logic                i_cfg_we,
    input  surs_pkg::t_cfg_idx  i_cfg_idx,
    input  surs_pkg::t_cfg_data i_cfg_data,
    // channels
    surs_in_if.sink             i_frac,
    surs_out_if.source          o_res
);
    import surs_pkg::*;

    // ------------------------------------------------------------------
    // Saturating Q7.16 helpers
    // ------------------------------------------------------------------
    function automatic t_dev sat_add(input t_dev a, input t_frac b);
        logic signed [DEV_W:0] s;
        s = {a[DEV_W-1], a} + {{(DEV_W+1-FRAC_W){1'b0}}, b};
        if (s[DEV_W] != s[DEV_W-1]) begin
            sat_add = s[DEV_W] ? DEV_MIN : DEV_MAX;
        end else begin
            sat_add = s[DEV_W-1:0];
        end
    endfunction

    function automatic t_dev sat_sub(input t_dev a, input t_frac b);
        logic signed [DEV_W:0] s;
        s = {a[DEV_W-1], a} - {{(DEV_W+1-FRAC_W){1'b0}}, b};
        if (s[DEV_W] != s[DEV_W-1]) begin
            sat_sub = s[DEV_W] ? DEV_MIN : DEV_MAX;
        end else begin
            sat_sub = s[DEV_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    t_cnt  r_ctrl_cnt;
    logic  r_vanish;
    t_frac r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_cnt <= CTRL_RESET;
            r_vanish   <= 1'b0;
            r_tol      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONTROLS_IN_USE: r_ctrl_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_VANISHING_MODE:  r_vanish   <= i_cfg_data[0];
                CFG_ZERO_TOLERANCE:  r_tol      <= i_cfg_data[FRAC_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Effective step length: 0 acts as 1, anything past the array size clamps.
    t_cnt step_len;
    always_comb begin
        if (r_ctrl_cnt == '0) begin
            step_len = t_cnt'(1);
        end else if (r_ctrl_cnt > CTRL_MAX) begin
            step_len = CTRL_MAX;
        end else begin
            step_len = r_ctrl_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic  r_in_vld;
    t_frac r_frac;

    // ------------------------------------------------------------------
    // Stage 2 state: deviations and the running maximum of the step
    // ------------------------------------------------------------------
    t_dev r_dev [MAX_CONTROLS];
    t_idx r_pos;
    t_dev r_best_dev;
    t_idx r_best_idx;
    logic r_best_found;

    // output register
    logic r_out_vld;
    t_idx r_out_idx;
    logic r_out_none;

    // ------------------------------------------------------------------
    // Stage 2 combinational pass
    // ------------------------------------------------------------------
    t_dev dev_new;      // deviation of the current component after the add
    logic eligible;
    logic take;         // current component becomes the new maximum
    logic cand_found;
    t_idx cand_idx;
    t_dev cand_dev;
    t_dev dev_sub;      // chosen deviation minus 1.0
    logic s2_last;      // this request closes the step
    logic out_free;
    logic s2_go;        // stage 2 commits this cycle

    always_comb begin
        dev_new  = sat_add(r_dev[r_pos], r_frac);
        eligible = !(r_vanish && (r_frac <= r_tol));
        // strict compare: lowest index keeps a tie
        take     = eligible && (!r_best_found || (dev_new > r_best_dev));

        cand_found = r_best_found || take;
        cand_idx   = take ? r_pos   : r_best_idx;
        cand_dev   = take ? dev_new : r_best_dev;

        // Positions only rise within a step, so the stored best deviation is
        // still the current value of that entry; no second read needed.
        dev_sub  = sat_sub(cand_dev, ONE_Q16);

        s2_last  = ({1'b0, r_pos} + t_cnt'(1)) >= step_len;
        out_free = !r_out_vld || o_res.ready;
        // a non-closing request never waits on the output side
        s2_go    = r_in_vld && (!s2_last || out_free);
    end

    assign i_frac.ready = !r_in_vld || s2_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_frac.ready) begin
            r_in_vld <= i_frac.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frac.valid && i_frac.ready) begin
            r_frac <= i_frac.fraction;
        end
    end

    // Deviation file: written at the current position, and on step end at
    // the chosen entry; the latter wins when both hit the same entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CONTROLS; i++) begin
                r_dev[i] <= '0;
            end
        end else if (s2_go) begin
            for (int i = 0; i < MAX_CONTROLS; i++) begin
                if (s2_last && cand_found && (cand_idx == t_idx'(i))) begin
                    r_dev[i] <= dev_sub;
                end else if (r_pos == t_idx'(i)) begin
                    r_dev[i] <= dev_new;
                end
            end
        end
    end

    // Step position and running maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_best_dev   <= '0;
            r_best_idx   <= '0;
            r_best_found <= 1'b0;
        end else if (s2_go) begin
            if (s2_last) begin
                r_pos        <= '0;
                r_best_dev   <= '0;
                r_best_idx   <= '0;
                r_best_found <= 1'b0;
            end else begin
                r_pos        <= r_pos + t_idx'(1);
                r_best_dev   <= cand_dev;
                r_best_idx   <= cand_idx;
                r_best_found <= cand_found;
            end
        end
    end

    // Output register: refilled whenever it is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= s2_go && s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s2_go && s2_last) begin
            r_out_idx  <= cand_found ? cand_idx : '0;
            r_out_none <= !cand_found;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.chosen_index  = r_out_idx;
    assign o_res.none_eligible = r_out_none;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_none_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.none_eligible |-> o_res.chosen_index == '0)
        else $error("none_eligible result with nonzero index");

    a_step_clears_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && s2_last |=> !r_best_found && (r_pos == '0))
        else $error("running maximum not cleared at step end");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frac.valid && i_frac.ready |=> r_in_vld)
        else $error("accepted request lost before stage 2");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s2_go && s2_last))
        else $error("result appeared without a closing request");

endmodule
